@@ rtl/core/rtcep_pkg.sv @@
`default_nettype none

package rtcep_pkg;

	// status B format bits and the hour byte PM flag
	localparam int unsigned BIN_MODE_BIT = 2;
	localparam int unsigned H24_MODE_BIT = 1;
	localparam int unsigned PM_BIT       = 7;

	localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
	localparam logic [10:0] EPOCH_YEAR     = 11'd1970;
	localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
	// leap years counted through 1969: 492 - 19 + 4
	localparam logic [8:0]  LEAPS_TO_EPOCH = 9'd477;
	localparam logic [13:0] CUR_YEAR_RST   = 14'd2022;
	localparam logic [7:0]  CUR_HUND_RST   = 8'd20;

	// x/100 = (x*5243)>>19 for x < 16384, x/25 = (x*5243)>>17 for x < 6400
	localparam logic [12:0] DIV_RECIP      = 13'd5243;

	typedef enum logic [0:0] {
		CFG_CENTURY_PRESENT = 1'b0,
		CFG_PIVOT_YEAR      = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic        century_present;
		logic [13:0] pivot_year;
		logic [7:0]  cur_hund;
	} rtcep_cfg_t;

	typedef struct packed {
		logic [7:0]  seconds;
		logic [7:0]  minutes;
		logic [6:0]  hour;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [14:0] year;
		logic        bad;
	} rtcep_item_t;

	typedef struct packed {
		logic [23:0] days;
		logic [18:0] hms;
		logic [14:0] year;
		logic [6:0]  hour;
		logic        bad;
	} rtcep_days_t;

	function automatic logic [7:0] bcd8(input logic [7:0] b);
		return {4'd0, b[3:0]} + 8'(b[7:4]) * 8'd10;
	endfunction

	// v <= 139, so five compare-subtract steps are enough
	function automatic logic [4:0] mod24(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (r >= 8'd24) begin
				r = r - 8'd24;
			end
		end
		return r[4:0];
	endfunction

	// days in the whole months before month idx+1, common year
	function automatic logic [8:0] cum_days(input logic [3:0] idx);
		logic [8:0] d;
		case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/rtcep_decode.sv @@
`default_nettype none

module rtcep_decode (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire rtcep_pkg::rtcep_cfg_t cfg,
	input  wire logic [7:0]            raw_seconds,
	input  wire logic [7:0]            raw_minutes,
	input  wire logic [7:0]            raw_hours,
	input  wire logic [7:0]            raw_day,
	input  wire logic [7:0]            raw_month,
	input  wire logic [7:0]            raw_year,
	input  wire logic [7:0]            raw_century,
	input  wire logic [7:0]            status_b,
	output logic                       valid_s1,
	output rtcep_pkg::rtcep_item_t     item_s1
);

	logic                   bin_mode;
	logic                   pm;
	logic [7:0]             yr_d;
	logic [7:0]             cen_d;
	logic [6:0]             hour_raw;
	logic [14:0]            win_year;
	rtcep_pkg::rtcep_item_t item_d;

	always_comb begin
		bin_mode = status_b[rtcep_pkg::BIN_MODE_BIT];
		pm       = raw_hours[rtcep_pkg::PM_BIT];

		item_d.seconds = bin_mode ? raw_seconds : rtcep_pkg::bcd8(raw_seconds);
		item_d.minutes = bin_mode ? raw_minutes : rtcep_pkg::bcd8(raw_minutes);
		item_d.day     = bin_mode ? raw_day     : rtcep_pkg::bcd8(raw_day);
		item_d.month   = bin_mode ? raw_month   : rtcep_pkg::bcd8(raw_month);
		yr_d           = bin_mode ? raw_year    : rtcep_pkg::bcd8(raw_year);
		cen_d          = bin_mode ? raw_century : rtcep_pkg::bcd8(raw_century);

		// hour tens digit is bits 6..4 only; bit 7 is PM
		hour_raw = bin_mode ? raw_hours[6:0]
		                    : 7'(raw_hours[3:0]) + 7'(raw_hours[6:4]) * 7'd10;
		item_d.hour = hour_raw;
		if (!status_b[rtcep_pkg::H24_MODE_BIT]) begin
			if (hour_raw == 7'd12) begin
				item_d.hour = pm ? 7'd12 : 7'd0;
			end else if (pm) begin
				item_d.hour = 7'(rtcep_pkg::mod24(8'(hour_raw) + 8'd12));
			end
		end

		// two-digit year: century byte, or window starting at the pivot year
		win_year = 15'(cfg.cur_hund) * 15'd100 + 15'(yr_d);
		if (win_year < 15'(cfg.pivot_year)) begin
			win_year = win_year + 15'd100;
		end
		if (yr_d >= 8'd100) begin
			item_d.year = 15'(yr_d);
		end else if (cfg.century_present) begin
			item_d.year = 15'(yr_d) + 15'(cen_d) * 15'd100;
		end else begin
			item_d.year = win_year;
		end

		item_d.bad = (item_d.month == 8'd0) || (item_d.day == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_d;
	end

endmodule

`default_nettype wire

@@ rtl/core/rtcep_calendar.sv @@
`default_nettype none

module rtcep_calendar (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         valid_s1,
	input  wire rtcep_pkg::rtcep_item_t item_s1,
	output logic                        valid_s3,
	output rtcep_pkg::rtcep_days_t      days_s3
);

	// stage 2: quotients by 100 of year-1 and year, month table, time of day
	logic [14:0] prev_year;
	logic [12:0] q4n_d;
	logic [12:0] q4y_d;
	logic [25:0] prod_n;
	logic [25:0] prod_y;
	logic [3:0]  midx;
	logic [18:0] hms_d;

	logic                   valid_s2;
	rtcep_pkg::rtcep_item_t item_s2;
	logic [12:0]            q4n_s2;
	logic [12:0]            q4y_s2;
	logic [8:0]             hn_s2;
	logic [8:0]             hy_s2;
	logic [8:0]             cum_s2;
	logic                   feb_s2;
	logic [18:0]            hms_s2;

	always_comb begin
		prev_year = item_s1.year - 15'd1;
		q4n_d     = prev_year[14:2];
		q4y_d     = item_s1.year[14:2];
		prod_n    = 26'(q4n_d) * 26'(rtcep_pkg::DIV_RECIP);
		prod_y    = 26'(q4y_d) * 26'(rtcep_pkg::DIV_RECIP);
		if (item_s1.month == 8'd0) begin
			midx = 4'd0;
		end else if (item_s1.month >= 8'd13) begin
			midx = 4'd12;
		end else begin
			midx = 4'(item_s1.month - 8'd1);
		end
		hms_d = 19'(item_s1.hour) * 19'(rtcep_pkg::SECS_PER_HOUR)
		      + 19'(item_s1.minutes) * 19'(rtcep_pkg::SECS_PER_MIN)
		      + 19'(item_s1.seconds);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= item_s1;
		q4n_s2  <= q4n_d;
		q4y_s2  <= q4y_d;
		hn_s2   <= prod_n[25:17];
		hy_s2   <= prod_y[25:17];
		cum_s2  <= rtcep_pkg::cum_days(midx);
		feb_s2  <= item_s1.month >= 8'd3;
		hms_s2  <= hms_d;
	end

	// stage 3: day count since 1970
	logic [12:0]           leaps;
	logic [14:0]           yoff;
	logic [23:0]           year_days;
	logic                  leap;
	rtcep_pkg::rtcep_days_t days_d;

	always_comb begin
		leaps = q4n_s2 - 13'(hn_s2) + 13'(hn_s2[8:2]);
		yoff  = item_s2.year - 15'(rtcep_pkg::EPOCH_YEAR);
		if (item_s2.year <= 15'(rtcep_pkg::EPOCH_YEAR)) begin
			year_days = 24'd0;
		end else begin
			year_days = 24'(yoff) * 24'(rtcep_pkg::DAYS_PER_YEAR) + 24'(leaps)
			          - 24'(rtcep_pkg::LEAPS_TO_EPOCH);
		end
		// y%100 == 0 when (y/100)*25 == y/4; y%400 == 0 when also (y/100)%4 == 0
		leap = (item_s2.year[1:0] == 2'd0)
		    && ((13'(hy_s2) * 13'd25 != q4y_s2) || (hy_s2[1:0] == 2'd0));
		days_d.days = year_days + 24'(cum_s2) + 24'(feb_s2 && leap)
		            + 24'(item_s2.day) - 24'd1;
		days_d.hms  = hms_s2;
		days_d.year = item_s2.year;
		days_d.hour = item_s2.hour;
		days_d.bad  = item_s2.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		days_s3 <= days_d;
	end

endmodule

`default_nettype wire

@@ rtl/core/rtcep_scale.sv @@
`default_nettype none

module rtcep_scale (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         valid_s3,
	input  wire rtcep_pkg::rtcep_days_t days_s3,
	output logic                        done,
	output logic [39:0]                 epoch_seconds,
	output logic [14:0]                 full_year,
	output logic [6:0]                  hour_of_day,
	output logic                        invalid
);

	logic [39:0] secs_d;

	always_comb begin
		secs_d = 40'(days_s3.days) * 40'(rtcep_pkg::SECS_PER_DAY) + 40'(days_s3.hms);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		epoch_seconds <= days_s3.bad ? 40'd0 : secs_d;
		full_year     <= days_s3.year;
		hour_of_day   <= days_s3.hour;
		invalid       <= days_s3.bad;
	end

endmodule

`default_nettype wire

@@ rtl/core/rtc_registers_to_epoch_seconds_top.sv @@
// Channel   Ports                                          Transfer
// config    cfg_we, cfg_index, cfg_wdata                   cfg_we high at clk edge
// snapshot  start, busy, raw_* bytes, status_b             start high, busy low
// result    done, epoch_seconds, full_year, hour_of_day,   done high, one cycle
//           invalid
//
// One snapshot per cycle; busy stays low.
// After the transfer, decode, divide-by-100 products, day count, and
// the 24x17 seconds multiply each take one register stage.
// arst_n clears the stage valid bits and the config registers (century off, year 2022).
// The receiver cannot stall; done marks each result for exactly one cycle.
`default_nettype none

module rtc_registers_to_epoch_seconds_top (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [13:0] cfg_wdata,
	input  wire              start,
	output logic             busy,
	input  wire logic [7:0]  raw_seconds,
	input  wire logic [7:0]  raw_minutes,
	input  wire logic [7:0]  raw_hours,
	input  wire logic [7:0]  raw_day,
	input  wire logic [7:0]  raw_month,
	input  wire logic [7:0]  raw_year,
	input  wire logic [7:0]  raw_century,
	input  wire logic [7:0]  status_b,
	output logic             done,
	output logic [39:0]      epoch_seconds,
	output logic [14:0]      full_year,
	output logic [6:0]       hour_of_day,
	output logic             invalid
);

	logic                   century_present_q;
	logic [13:0]            pivot_year_q;
	logic [7:0]             cur_hund_q;
	logic [26:0]            hund_prod;
	rtcep_pkg::rtcep_cfg_t  cfg;

	logic                   valid_s1;
	rtcep_pkg::rtcep_item_t item_s1;
	logic                   valid_s3;
	rtcep_pkg::rtcep_days_t days_s3;

	assign busy      = 1'b0;
	// hundreds of the pivot year, kept alongside it
	assign hund_prod = 27'(cfg_wdata) * 27'(rtcep_pkg::DIV_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			century_present_q <= 1'b0;
			pivot_year_q      <= rtcep_pkg::CUR_YEAR_RST;
			cur_hund_q        <= rtcep_pkg::CUR_HUND_RST;
		end else if (cfg_we) begin
			if (cfg_index == rtcep_pkg::CFG_CENTURY_PRESENT) begin
				century_present_q <= cfg_wdata[0];
			end
			if (cfg_index == rtcep_pkg::CFG_PIVOT_YEAR) begin
				pivot_year_q <= cfg_wdata;
				cur_hund_q   <= hund_prod[26:19];
			end
		end
	end

	always_comb begin
		cfg.century_present = century_present_q;
		cfg.pivot_year      = pivot_year_q;
		cfg.cur_hund        = cur_hund_q;
	end

	rtcep_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start && !busy),
		.cfg         (cfg),
		.raw_seconds (raw_seconds),
		.raw_minutes (raw_minutes),
		.raw_hours   (raw_hours),
		.raw_day     (raw_day),
		.raw_month   (raw_month),
		.raw_year    (raw_year),
		.raw_century (raw_century),
		.status_b    (status_b),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1)
	);

	rtcep_calendar u_calendar (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.valid_s3 (valid_s3),
		.days_s3  (days_s3)
	);

	rtcep_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s3      (valid_s3),
		.days_s3       (days_s3),
		.done          (done),
		.epoch_seconds (epoch_seconds),
		.full_year     (full_year),
		.hour_of_day   (hour_of_day),
		.invalid       (invalid)
	);

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("snapshot transfer did not produce a result four cycles later");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid |-> epoch_seconds == 40'd0)
		else $error("invalid result carries nonzero seconds");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> full_year <= 15'd25599)
		else $error("decoded year out of range");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> valid_s1 == $past(start, 1) && $past(valid_s3, 1))
		else $error("result strobe without a snapshot in flight");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_rtc_registers_to_epoch_seconds_top.sv @@
`default_nettype none

module tb_rtc_registers_to_epoch_seconds_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic [7:0] seconds;
		logic [7:0] minutes;
		logic [7:0] hours;
		logic [7:0] day;
		logic [7:0] month;
		logic [7:0] year;
		logic [7:0] century;
		logic [7:0] status;
	} snapshot_t;

	typedef struct packed {
		logic [39:0] epoch;
		logic [14:0] year;
		logic [6:0]  hour;
		logic        bad;
	} decoded_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [13:0] cfg_wdata;
	logic        start;
	logic        busy;
	logic [7:0]  raw_seconds;
	logic [7:0]  raw_minutes;
	logic [7:0]  raw_hours;
	logic [7:0]  raw_day;
	logic [7:0]  raw_month;
	logic [7:0]  raw_year;
	logic [7:0]  raw_century;
	logic [7:0]  status_b;
	logic        done;
	logic [39:0] epoch_seconds;
	logic [14:0] full_year;
	logic [6:0]  hour_of_day;
	logic        invalid;

	// shadow of the block's registers
	logic        century_en;
	logic [13:0] pivot_year;

	decoded_t    pending_dates[$];
	int          error_count;
	int          idle_pct;
	int          cycle_count;

	rtc_registers_to_epoch_seconds_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.raw_seconds   (raw_seconds),
		.raw_minutes   (raw_minutes),
		.raw_hours     (raw_hours),
		.raw_day       (raw_day),
		.raw_month     (raw_month),
		.raw_year      (raw_year),
		.raw_century   (raw_century),
		.status_b      (status_b),
		.done          (done),
		.epoch_seconds (epoch_seconds),
		.full_year     (full_year),
		.hour_of_day   (hour_of_day),
		.invalid       (invalid)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned bcd_value(logic [7:0] b);
		return longint'(b[3:0]) + 10 * longint'(b[7:4]);
	endfunction

	function automatic longint unsigned leaps_upto(longint unsigned n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic longint unsigned month_length(int idx, longint unsigned y);
		longint unsigned len;
		case (idx)
			1:       len = ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
			3, 5, 8, 10: len = 30;
			default: len = 31;
		endcase
		return len;
	endfunction

	function automatic decoded_t predict_epoch(snapshot_t s);
		longint unsigned secs, mins, hour, day, month, yr, cen, year, days, last, total;
		logic pm;
		decoded_t r;
		pm = s.hours[rtcep_pkg::PM_BIT];
		if (!s.status[rtcep_pkg::BIN_MODE_BIT]) begin
			secs  = bcd_value(s.seconds);
			mins  = bcd_value(s.minutes);
			hour  = longint'(s.hours[3:0]) + 10 * longint'(s.hours[6:4]);
			day   = bcd_value(s.day);
			month = bcd_value(s.month);
			yr    = bcd_value(s.year);
			cen   = bcd_value(s.century);
		end else begin
			secs  = s.seconds;
			mins  = s.minutes;
			hour  = s.hours[6:0];
			day   = s.day;
			month = s.month;
			yr    = s.year;
			cen   = s.century;
		end
		if (!s.status[rtcep_pkg::H24_MODE_BIT]) begin
			if (hour == 12)
				hour = pm ? 12 : 0;
			else if (pm)
				hour = (hour + 12) % 24;
		end
		year = yr;
		if (yr < 100) begin
			if (century_en) begin
				year = yr + cen * 100;
			end else begin
				year = yr + (pivot_year / 100) * 100;
				if (year < pivot_year)
					year += 100;
			end
		end
		r.bad = (month == 0) || (day == 0);
		days = 0;
		if (year > 1970)
			days = 365 * (year - 1970) + leaps_upto(year - 1) - leaps_upto(1969);
		// months past December add nothing
		last = (month == 0) ? 0 : month - 1;
		if (last > 12)
			last = 12;
		for (int i = 0; i < last; i++)
			days += month_length(i, year);
		total = (days + day - 1) * 86400 + hour * 3600 + mins * 60 + secs;
		r.epoch = r.bad ? 40'd0 : total[39:0];
		r.year  = year[14:0];
		r.hour  = hour[6:0];
		return r;
	endfunction

	function automatic snapshot_t mk_snap(logic [7:0] sec, logic [7:0] mins, logic [7:0] hr,
			logic [7:0] day, logic [7:0] mon, logic [7:0] yr, logic [7:0] cen, logic [7:0] fmt);
		snapshot_t s;
		s = '{sec, mins, hr, day, mon, yr, cen, fmt};
		return s;
	endfunction

	function automatic logic [7:0] encode_field(int unsigned v, logic bin_mode);
		logic [7:0] b;
		if (bin_mode)
			b = v[7:0];
		else
			b = 8'(((v / 10) << 4) | (v % 10));
		return b;
	endfunction

	// mostly plausible clock readings with random content, the rest raw noise
	function automatic snapshot_t random_snapshot();
		snapshot_t s;
		logic bin_mode, h24;
		logic [7:0] hr;
		s = {$urandom, $urandom};
		if ($urandom_range(9) < 2)
			return s;
		bin_mode  = s.status[rtcep_pkg::BIN_MODE_BIT];
		h24       = s.status[rtcep_pkg::H24_MODE_BIT];
		hr        = encode_field(h24 ? $urandom_range(23) : $urandom_range(1, 12), bin_mode);
		s.hours   = {1'($urandom_range(1)), hr[6:0]};
		s.seconds = encode_field($urandom_range(59), bin_mode);
		s.minutes = encode_field($urandom_range(59), bin_mode);
		s.day     = encode_field($urandom_range(1, 31), bin_mode);
		s.month   = encode_field($urandom_range(1, 12), bin_mode);
		s.year    = encode_field($urandom_range(99), bin_mode);
		s.century = encode_field($urandom_range(3) == 0 ? $urandom_range(99)
			: $urandom_range(19, 21), bin_mode);
		return s;
	endfunction

	task automatic send_snapshot(snapshot_t s);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		raw_seconds <= s.seconds;
		raw_minutes <= s.minutes;
		raw_hours   <= s.hours;
		raw_day     <= s.day;
		raw_month   <= s.month;
		raw_year    <= s.year;
		raw_century <= s.century;
		status_b    <= s.status;
		do
			@(posedge clk);
		while (busy);
		pending_dates.push_back(predict_epoch(s));
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(rtcep_pkg::cfg_index_t idx, logic [13:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rtcep_pkg::CFG_CENTURY_PRESENT: century_en = value[0];
			rtcep_pkg::CFG_PIVOT_YEAR:      pivot_year = value;
			default:                        ;
		endcase
	endtask

	task automatic test_hour_formats;
		send_snapshot(mk_snap(8'h59, 8'h59, 8'h12, 8'h31, 8'h12, 8'h99, 8'h20, 8'h00));
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h30, 8'h20, 8'h00));
		send_snapshot(mk_snap(8'h30, 8'h15, 8'h91, 8'h15, 8'h06, 8'h45, 8'h20, 8'h00));
		send_snapshot(mk_snap(8'h01, 8'h02, 8'h95, 8'h10, 8'h10, 8'h50, 8'h20, 8'h02));
		send_snapshot(mk_snap(8'd5, 8'd6, 8'h8C, 8'd7, 8'd8, 8'd40, 8'd20, 8'h04));
		send_snapshot(mk_snap(8'd59, 8'd59, 8'hFF, 8'd28, 8'd2, 8'd60, 8'd20, 8'h06));
		send_snapshot(mk_snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		// nibbles above nine decode without any range check
		send_snapshot(mk_snap(8'hAF, 8'hFA, 8'h7F, 8'hAF, 8'h1F, 8'h9F, 8'hFF, 8'hF9));
	endtask

	task automatic test_invalid_dates;
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_snapshot(mk_snap(8'h10, 8'h20, 8'h08, 8'h15, 8'h00, 8'h33, 8'h20, 8'h02));
		send_snapshot(mk_snap(8'd10, 8'd20, 8'd8, 8'd0, 8'd7, 8'd33, 8'd20, 8'h06));
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h00, 8'h05, 8'h13, 8'h25, 8'h20, 8'h02));
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h24, 8'h20, 8'h02));
	endtask

	task automatic test_year_window;
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h21, 8'h00, 8'h02));
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h22, 8'h00, 8'h02));
		send_snapshot(mk_snap(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd100, 8'd0, 8'h06));
		drain();
		write_reg(rtcep_pkg::CFG_PIVOT_YEAR, 14'd9999);
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h00, 8'h31, 8'h12, 8'h98, 8'h00, 8'h02));
		send_snapshot(mk_snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h00, 8'h02));
		drain();
		write_reg(rtcep_pkg::CFG_PIVOT_YEAR, 14'd2000);
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h00, 8'h02));
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h99, 8'h00, 8'h02));
	endtask

	task automatic test_century_byte;
		drain();
		write_reg(rtcep_pkg::CFG_CENTURY_PRESENT, 14'd1);
		send_snapshot(mk_snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19, 8'h02));
		send_snapshot(mk_snap(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h70, 8'h19, 8'h00));
		send_snapshot(mk_snap(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd99, 8'd255, 8'h06));
		send_snapshot(mk_snap(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd112, 8'd255, 8'h06));
	endtask

	task automatic test_random_snapshots(int pct, int count);
		int unsigned yr_pick;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				drain();
				yr_pick = $urandom_range(3);
				write_reg(rtcep_pkg::CFG_CENTURY_PRESENT, 14'($urandom));
				write_reg(rtcep_pkg::CFG_PIVOT_YEAR, yr_pick == 0 ? 14'd2000
					: yr_pick == 1 ? 14'd9999 : 14'($urandom_range(2000, 9999)));
			end
			send_snapshot(random_snapshot());
		end
	endtask

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				$display("%0t: result with nothing outstanding, epoch_seconds %0d",
					$time, epoch_seconds);
				error_count++;
			end else begin
				want = pending_dates.pop_front();
				if (epoch_seconds !== want.epoch) begin
					$display("%0t: epoch_seconds expected %0d actual %0d",
						$time, want.epoch, epoch_seconds);
					error_count++;
				end
				if (full_year !== want.year) begin
					$display("%0t: full_year expected %0d actual %0d",
						$time, want.year, full_year);
					error_count++;
				end
				if (hour_of_day !== want.hour) begin
					$display("%0t: hour_of_day expected %0d actual %0d",
						$time, want.hour, hour_of_day);
					error_count++;
				end
				if (invalid !== want.bad) begin
					$display("%0t: invalid expected %0b actual %0b",
						$time, want.bad, invalid);
					error_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("rtc_registers_to_epoch_seconds_top: mismatch");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		start       = 1'b0;
		raw_seconds = '0;
		raw_minutes = '0;
		raw_hours   = '0;
		raw_day     = '0;
		raw_month   = '0;
		raw_year    = '0;
		raw_century = '0;
		status_b    = '0;
		century_en  = 1'b0;
		pivot_year  = 14'd2022;
		error_count = 0;
		idle_pct    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_hour_formats();
		test_invalid_dates();
		test_year_window();
		test_century_byte();
		test_random_snapshots(7, 200);
		test_random_snapshots(45, 200);
		test_random_snapshots(0, 200);

		drain();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("rtc_registers_to_epoch_seconds_top: match");
		end else begin
			$display("rtc_registers_to_epoch_seconds_top: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/rtcep_pkg.sv
rtl/core/rtcep_decode.sv
rtl/core/rtcep_calendar.sv
rtl/core/rtcep_scale.sv
rtl/core/rtc_registers_to_epoch_seconds_top.sv
tb/sv/tb_rtc_registers_to_epoch_seconds_top.sv
